### hw/rtl/itad_pkg.sv
package itad_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int VALUE_BITS = 32;
  localparam int BASE_BITS = 8;
  localparam int CHAR_BITS = 8;

  localparam logic [BASE_BITS-1:0] BASE_BIN = 8'd2;
  localparam logic [BASE_BITS-1:0] BASE_OCT = 8'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC = 8'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX = 8'd16;

  localparam logic [CHAR_BITS-1:0] CHAR_MARK = 8'h78;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;

  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_BITS-1:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else begin
      c = 8'h37 + {4'd0, d};
    end
    return c;
  endfunction

  function automatic logic [31:0] pow10(input logic [3:0] k);
    logic [31:0] p;
    unique case (k)
      4'd0: p = 32'd1;
      4'd1: p = 32'd10;
      4'd2: p = 32'd100;
      4'd3: p = 32'd1000;
      4'd4: p = 32'd10000;
      4'd5: p = 32'd100000;
      4'd6: p = 32'd1000000;
      4'd7: p = 32'd10000000;
      4'd8: p = 32'd100000000;
      4'd9: p = 32'd1000000000;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

  // Exponent of the largest power of the radix that fits in the given width.
  function automatic int top_exp(input int radix, input int width);
    longint maxv;
    longint p;
    int e;
    maxv = (longint'(1) << width) - 1;
    p = 1;
    e = 0;
    while (p * radix <= maxv) begin
      p = p * radix;
      e = e + 1;
    end
    return e;
  endfunction

endpackage

### hw/rtl/itad_if.sv
interface itad_number_if;
  import itad_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [BASE_BITS-1:0]  base;
  logic                  is_signed;

  modport source (output valid, value, base, is_signed, input ready);
  modport sink (input valid, value, base, is_signed, output ready);
endinterface

interface itad_char_if;
  import itad_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] char_out;
  logic                 last;

  modport source (output valid, char_out, last, input ready);
  modport sink (input valid, char_out, last, output ready);
endinterface

### hw/rtl/integer_to_ascii_digits.sv
// Integer to ASCII digits converter.
// The number channel takes one request: value, base and is_signed. The text
// channel returns its ASCII characters one at a time, most significant
// digit first, with last set on the final character. Bases 2, 8, 10 and 16
// are converted directly; any other base gives an 'x' and then hex digits.
// Signed negative values in base 10 give a '-' and then the magnitude.
// Each digit is found by subtracting the current power of the base with one
// shared compare-and-subtract unit, one subtraction per cycle. The number
// channel is not ready while a conversion runs; it becomes ready as soon as
// the final character is in the output register, so the next number can load
// while that character waits. When the receiver stalls, the character stays in
// the output register and the converter waits before writing the next one.
// A synchronous reset returns to idle and drops any character not yet taken.
module integer_to_ascii_digits #(
  parameter int VALUE_WIDTH = itad_pkg::DEFAULT_VALUE_WIDTH
) (
  input logic          clk,
  input logic          rst,
  itad_number_if.sink  number,
  itad_char_if.source  text
);
  import itad_pkg::*;

  localparam int EXP_W = $clog2(VALUE_WIDTH);
  localparam int E2 = top_exp(2, VALUE_WIDTH);
  localparam int E8 = top_exp(8, VALUE_WIDTH);
  localparam int E10 = top_exp(10, VALUE_WIDTH);
  localparam int E16 = top_exp(16, VALUE_WIDTH);
  localparam logic [VALUE_WIDTH-1:0] ONE = {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [VALUE_WIDTH-1:0] TOP_P2 = ONE << E2;
  localparam logic [VALUE_WIDTH-1:0] TOP_P8 = ONE << (3 * E8);
  localparam logic [VALUE_WIDTH-1:0] TOP_P16 = ONE << (4 * E16);
  localparam logic [VALUE_WIDTH-1:0] TOP_P10 = VALUE_WIDTH'(pow10(4'(E10)));

  typedef enum logic [1:0] {S_IDLE, S_MARK, S_MINUS, S_DIGIT} state_t;
  typedef enum logic [1:0] {R_BIN, R_OCT, R_DEC, R_HEX} radix_t;

  state_t                 state;
  radix_t                 radix;
  logic [VALUE_WIDTH-1:0] n;
  logic [VALUE_WIDTH-1:0] p;
  logic [EXP_W-1:0]       e;
  logic [3:0]             d;
  logic                   started;
  logic                   out_valid;
  logic [CHAR_BITS-1:0]   out_char;
  logic                   out_last;

  logic [VALUE_WIDTH-1:0] vmask;
  logic [VALUE_WIDTH-1:0] vneg;
  logic                   is_neg;
  logic                   base_ok;
  radix_t                 radix_in;
  logic [VALUE_WIDTH:0]   diff;
  logic                   fits;
  logic                   out_free;
  logic                   emit;
  logic                   out_load;
  logic [VALUE_WIDTH-1:0] p_down;

  assign vmask = number.value[VALUE_WIDTH-1:0];
  assign vneg = ~vmask + ONE;
  assign base_ok = (number.base == BASE_BIN) || (number.base == BASE_OCT) ||
                   (number.base == BASE_DEC) || (number.base == BASE_HEX);
  assign is_neg = (number.base == BASE_DEC) && number.is_signed && vmask[VALUE_WIDTH-1];

  always_comb begin
    priority if (number.base == BASE_BIN) begin
      radix_in = R_BIN;
    end else if (number.base == BASE_OCT) begin
      radix_in = R_OCT;
    end else if (number.base == BASE_DEC) begin
      radix_in = R_DEC;
    end else begin
      radix_in = R_HEX;
    end
  end

  // Shared compare-and-subtract unit: the borrow says whether the power fits.
  assign diff = {1'b0, n} - {1'b0, p};
  assign fits = ~diff[VALUE_WIDTH];
  assign out_free = !out_valid || text.ready;
  assign emit = (d != 4'd0) || started || (e == '0);
  assign out_load = out_free && ((state == S_MARK) || (state == S_MINUS) ||
                                 ((state == S_DIGIT) && !fits && emit));

  always_comb begin
    unique case (radix)
      R_BIN: p_down = p >> 1;
      R_OCT: p_down = p >> 3;
      R_DEC: p_down = VALUE_WIDTH'(pow10(4'(e - 1'b1)));
      R_HEX: p_down = p >> 4;
      default: p_down = p;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !text.ready);
      unique case (state)
        S_IDLE: begin
          if (number.valid) begin
            radix <= radix_in;
            n <= is_neg ? vneg : vmask;
            d <= 4'd0;
            started <= 1'b0;
            unique case (radix_in)
              R_BIN: begin
                e <= EXP_W'(E2);
                p <= TOP_P2;
              end
              R_OCT: begin
                e <= EXP_W'(E8);
                p <= TOP_P8;
              end
              R_DEC: begin
                e <= EXP_W'(E10);
                p <= TOP_P10;
              end
              R_HEX: begin
                e <= EXP_W'(E16);
                p <= TOP_P16;
              end
              default: begin
                e <= EXP_W'(E16);
                p <= TOP_P16;
              end
            endcase
            priority if (!base_ok) begin
              state <= S_MARK;
            end else if (is_neg) begin
              state <= S_MINUS;
            end else begin
              state <= S_DIGIT;
            end
          end
        end
        S_MARK: begin
          if (out_free) begin
            out_char <= CHAR_MARK;
            out_last <= 1'b0;
            state <= S_DIGIT;
          end
        end
        S_MINUS: begin
          if (out_free) begin
            out_char <= CHAR_MINUS;
            out_last <= 1'b0;
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (fits) begin
            n <= diff[VALUE_WIDTH-1:0];
            d <= d + 4'd1;
          end else if (!emit || out_free) begin
            if (emit) begin
              out_char <= digit_char(d);
              out_last <= (e == '0);
            end
            if (e == '0) begin
              state <= S_IDLE;
            end else begin
              e <= e - 1'b1;
              p <= p_down;
              d <= 4'd0;
              started <= started || (d != 4'd0);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign number.ready = (state == S_IDLE);
  assign text.valid = out_valid;
  assign text.char_out = out_char;
  assign text.last = out_last;

endmodule

### hw/rtl/itad_checker.sv
module itad_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           num_valid,
  input logic                           num_ready,
  input logic                           txt_valid,
  input logic                           txt_ready,
  input logic [itad_pkg::CHAR_BITS-1:0] txt_char,
  input logic                           txt_last
);
  import itad_pkg::*;

  // A waiting character stays offered and unchanged until it is taken.
  a_txt_hold: assert property (@(posedge clk) disable iff (rst)
    txt_valid && !txt_ready |=> txt_valid && $stable(txt_char) && $stable(txt_last))
    else $error("character changed or dropped while stalled");

  // Once a number is loaded, no other request is taken until it is converted.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    num_valid && num_ready |=> !num_ready)
    else $error("number channel ready during a conversion");

  // The converter frees up exactly when the final character enters the output.
  a_ready_on_last: assert property (@(posedge clk) disable iff (rst)
    $rose(num_ready) |-> txt_valid && txt_last)
    else $error("converter idle without a final character");

  // A marker is never the final character of a number.
  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    txt_valid && txt_last |-> (txt_char != CHAR_MARK) && (txt_char != CHAR_MINUS))
    else $error("marker flagged as final character");

endmodule

bind integer_to_ascii_digits itad_checker u_itad_checker (
  .clk       (clk),
  .rst       (rst),
  .num_valid (number.valid),
  .num_ready (number.ready),
  .txt_valid (text.valid),
  .txt_ready (text.ready),
  .txt_char  (text.char_out),
  .txt_last  (text.last)
);

### sim/tb_integer_to_ascii_digits.sv
module tb_integer_to_ascii_digits;
  timeunit 1ns;
  timeprecision 1ps;

  import itad_pkg::*;

  localparam int VW = 32;
  localparam int RANDOM_NUMBERS = 225;
  localparam int DIRECTED_ROWS = 25;
  localparam int STALL_CYCLES = 400;
  localparam string DIGIT_SET = "0123456789ABCDEF";

  typedef struct {
    logic [CHAR_BITS-1:0] ch;
    logic                 last;
  } char_item_t;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic [BASE_BITS-1:0]  base;
    logic                  is_signed;
    string                 typed;
  } number_row_t;

  logic clk = 1'b0;
  logic rst;

  itad_number_if number_ch ();
  itad_char_if   text_ch ();

  integer_to_ascii_digits #(
    .VALUE_WIDTH(VW)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .number (number_ch),
    .text   (text_ch)
  );

  always #6 clk = ~clk;

  char_item_t  expected_chars[$];
  number_row_t directed_rows[DIRECTED_ROWS];
  int          errors = 0;
  int          numbers_sent = 0;
  int          chars_checked = 0;
  int          minus_numbers = 0;
  int          marked_numbers = 0;
  bit          no_gaps = 1'b0;
  bit          stall_done = 1'b0;

  function automatic bit is_known_base(input logic [BASE_BITS-1:0] b);
    return b == BASE_BIN || b == BASE_OCT || b == BASE_DEC || b == BASE_HEX;
  endfunction

  function automatic void push_char(input logic [CHAR_BITS-1:0] c);
    char_item_t item;
    item.ch = c;
    item.last = 1'b0;
    expected_chars.push_back(item);
  endfunction

  function automatic void mark_last();
    expected_chars[expected_chars.size() - 1].last = 1'b1;
  endfunction

  function automatic void queue_digits(input logic [VALUE_BITS-1:0] value,
                                       input logic [BASE_BITS-1:0] base,
                                       input logic is_signed);
    longint unsigned maxv;
    longint unsigned n;
    longint unsigned radix;
    longint unsigned p;
    longint unsigned d;
    bit started;
    bit done;
    maxv = (64'd1 << VW) - 1;
    n = longint'(value) & maxv;
    started = 1'b0;
    done = 1'b0;
    if (is_known_base(base)) begin
      radix = base;
    end else begin
      push_char(CHAR_MARK);
      radix = 16;
    end
    if (radix == 10 && is_signed && ((n >> (VW - 1)) & 1) != 0) begin
      push_char(CHAR_MINUS);
      n = (0 - n) & maxv;
    end
    p = 1;
    while (p * radix <= maxv) p = p * radix;
    while (!done) begin
      d = n / p;
      n = n - d * p;
      if (d != 0) started = 1'b1;
      if (started || p == 1) push_char(DIGIT_SET[d & 15]);
      if (p == 1) begin
        done = 1'b1;
      end else begin
        p = p / radix;
      end
    end
    mark_last();
  endfunction

  function automatic void queue_text(input string typed);
    for (int i = 0; i < typed.len(); i++) push_char(typed[i]);
    mark_last();
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [BASE_BITS-1:0] pick_base();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return BASE_DEC;
    if (r < 45) return BASE_HEX;
    if (r < 60) return BASE_OCT;
    if (r < 75) return BASE_BIN;
    return BASE_BITS'($urandom_range(0, 255));
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value(input logic [BASE_BITS-1:0] base);
    longint unsigned radix;
    longint unsigned p;
    logic [VALUE_BITS-1:0] v;
    int k;
    int r;
    radix = is_known_base(base) ? longint'(base) : 16;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      v = $urandom;
    end else if (r < 45) begin
      v = $urandom_range(0, 20);
    end else if (r < 60) begin
      case ($urandom_range(0, 3))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0000;
        2: v = 32'h8000_0001;
        default: v = 32'hFFFF_FFFF;
      endcase
    end else if (r < 80) begin
      v = $urandom >> $urandom_range(0, 31);
    end else begin
      p = 1;
      k = $urandom_range(0, 31);
      while (k > 0 && p * radix <= 64'hFFFF_FFFF) begin
        p = p * radix;
        k--;
      end
      case ($urandom_range(0, 3))
        0: v = VALUE_BITS'(p);
        1: v = VALUE_BITS'(p - 1);
        2: v = VALUE_BITS'(0 - p);
        default: v = VALUE_BITS'(p * $urandom_range(1, int'(radix) - 1));
      endcase
    end
    return v;
  endfunction

  task automatic offer_number(input logic [VALUE_BITS-1:0] value,
                              input logic [BASE_BITS-1:0] base,
                              input logic is_signed,
                              input string typed);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      number_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    number_ch.valid     <= 1'b1;
    number_ch.value     <= value;
    number_ch.base      <= base;
    number_ch.is_signed <= is_signed;
    do @(posedge clk); while (!number_ch.ready);
    if (typed.len() == 0) begin
      queue_digits(value, base, is_signed);
    end else begin
      queue_text(typed);
    end
    numbers_sent++;
    if (!is_known_base(base)) marked_numbers++;
    if (base == BASE_DEC && is_signed && value[VW-1]) minus_numbers++;
  endtask

  initial begin
    directed_rows = '{
      '{32'd0,          BASE_DEC, 1'b0, "0"},
      '{32'd0,          BASE_BIN, 1'b0, "0"},
      '{32'd0,          BASE_OCT, 1'b1, "0"},
      '{32'd0,          BASE_HEX, 1'b1, "0"},
      '{32'hFFFF_FFFF,  BASE_DEC, 1'b0, "4294967295"},
      '{32'hFFFF_FFFF,  BASE_HEX, 1'b0, "FFFFFFFF"},
      '{32'hFFFF_FFFF,  BASE_OCT, 1'b0, "37777777777"},
      '{32'hFFFF_FFFF,  BASE_BIN, 1'b0, "11111111111111111111111111111111"},
      '{32'hFFFF_FFFF,  BASE_DEC, 1'b1, "-1"},
      '{32'h8000_0000,  BASE_DEC, 1'b1, "-2147483648"},
      '{32'h7FFF_FFFF,  BASE_DEC, 1'b1, "2147483647"},
      '{32'hFFFF_FFFF,  BASE_HEX, 1'b1, "FFFFFFFF"},
      '{32'h8000_0000,  BASE_BIN, 1'b1, ""},
      '{32'd0,          8'd0,     1'b0, "x0"},
      '{32'hFFFF_FFFF,  8'd255,   1'b1, "xFFFFFFFF"},
      '{32'd12345,      8'd3,     1'b0, ""},
      '{32'd1000000000, BASE_DEC, 1'b0, "1000000000"},
      '{32'd999999999,  BASE_DEC, 1'b0, ""},
      '{32'h1000_0000,  BASE_HEX, 1'b0, "10000000"},
      '{32'o10000000000, BASE_OCT, 1'b0, "10000000000"},
      '{32'hDEAD_BEEF,  BASE_HEX, 1'b0, "DEADBEEF"},
      '{32'd9,          BASE_DEC, 1'b1, "9"},
      '{32'h00AB_CDEF,  8'd1,     1'b0, ""},
      '{32'h8000_0000,  BASE_OCT, 1'b1, ""},
      '{32'd255,        BASE_BIN, 1'b0, "11111111"}
    };
  end

  initial begin
    logic [BASE_BITS-1:0] base;
    rst <= 1'b1;
    number_ch.valid     <= 1'b0;
    number_ch.value     <= '0;
    number_ch.base      <= '0;
    number_ch.is_signed <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_number(directed_rows[i].value, directed_rows[i].base,
                   directed_rows[i].is_signed, directed_rows[i].typed);
    end

    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      if (i % 20 == 0) no_gaps = ($urandom_range(0, 4) == 0);
      base = pick_base();
      offer_number(pick_value(base), base, 1'($urandom_range(0, 1)), "");
    end
    number_ch.valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Converted %0d numbers into %0d characters, %0d negative in base 10,",
             numbers_sent, chars_checked, minus_numbers);
    $display("%0d with an unsupported base; the text side saw random stalls and %0s",
             marked_numbers, $sformatf("one hold-off of %0d cycles.", STALL_CYCLES));
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("tb_integer_to_ascii_digits passed");
    end else begin
      $display("tb_integer_to_ascii_digits failed");
    end
    $finish;
  end

  // The text side accepts in bursts and stalls once for a long stretch so that
  // the converter backs up and refuses new requests.
  initial begin
    int gap;
    text_ch.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (!stall_done && numbers_sent >= 30) begin
        text_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_done = 1'b1;
      end
      text_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        text_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    char_item_t want;
    if (!rst && text_ch.valid && text_ch.ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char 0x%02h last %0b",
                 $realtime, text_ch.char_out, text_ch.last);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (text_ch.char_out !== want.ch) begin
          $display("%0t: char_out mismatch: expected 0x%02h, actual 0x%02h",
                   $realtime, want.ch, text_ch.char_out);
          errors++;
        end
        if (text_ch.last !== want.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $realtime, want.last, text_ch.last);
          errors++;
        end
      end
    end
  end

  initial begin
    #60ms;
    $display("Timeout with %0d characters still expected.", expected_chars.size());
    $display("tb_integer_to_ascii_digits failed");
    $finish;
  end

endmodule

### integer_to_ascii_digits.f
hw/rtl/itad_pkg.sv
hw/rtl/itad_if.sv
hw/rtl/integer_to_ascii_digits.sv
hw/rtl/itad_checker.sv
sim/tb_integer_to_ascii_digits.sv
